/* rtl/hppc_pkg.sv */
// Package for the hall pulse position counter: field types, per-channel state,
// configuration record, register indexes and reset values. No dependencies.
`default_nettype none

package hppc_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int CH_BITS      = 2;
  localparam int SAMPLE_BITS  = 12;
  localparam int TRACK_BITS   = 16;
  localparam int POS_BITS     = 16;
  localparam int TIME_BITS    = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int IN_DATA_BITS  = 40;
  localparam int OUT_DATA_BITS = 24;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } opcode_t;

  localparam logic [1:0] DIR_IDLE = 2'd0;
  localparam logic [1:0] DIR_FW   = 2'd1;
  localparam logic [1:0] DIR_BW   = 2'd2;
  localparam logic [1:0] STALL_FW = 2'd1;
  localparam logic [1:0] STALL_BW = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_JUMP   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIAG_HIGH  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIAG_LOW   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_AMPL   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DECEL_TIME = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TICK_STEP  = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POS_MIN    = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POS_MAX    = 3'd7;

  localparam logic [TRACK_BITS-1:0] TRACK_MAX_CLR = 16'h0000;
  localparam logic [TRACK_BITS-1:0] TRACK_MIN_CLR = 16'hFFFF;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0]     max_jump;
    logic [SAMPLE_BITS-1:0]     diag_high;
    logic [SAMPLE_BITS-1:0]     diag_low;
    logic [SAMPLE_BITS-1:0]     min_ampl;
    logic [TIME_BITS-1:0]       decel_time;
    logic [TIME_BITS-1:0]       tick_step;
    logic signed [POS_BITS-1:0] pos_min;
    logic signed [POS_BITS-1:0] pos_max;
  } cfg_t;

  typedef struct packed {
    opcode_t                    opcode;
    logic [CH_BITS-1:0]         channel;
    logic [SAMPLE_BITS-1:0]     sample;
    logic [1:0]                 direction;
    logic [1:0]                 stall_req;
    logic signed [POS_BITS-1:0] new_position;
  } item_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0] position;
    logic                       level;
    logic [1:0]                 edges_counted;
    logic                       counting_active;
  } result_t;

  typedef struct packed {
    logic [1:0]                 last_dir;
    logic [TIME_BITS-1:0]       decel;
    logic [TRACK_BITS-1:0]      track_max;
    logic [TRACK_BITS-1:0]      track_min;
    logic [TRACK_BITS-1:0]      prev_max;
    logic [TRACK_BITS-1:0]      prev_min;
    logic                       sliced;
    logic                       rise_done;
    logic                       fall_done;
    logic                       armed;
    logic signed [POS_BITS-1:0] pos;
  } chan_state_t;

  localparam chan_state_t CHAN_RESET = '{
    last_dir:  DIR_IDLE,
    decel:     '0,
    track_max: TRACK_MAX_CLR,
    track_min: TRACK_MIN_CLR,
    prev_max:  TRACK_MAX_CLR,
    prev_min:  TRACK_MIN_CLR,
    sliced:    1'b0,
    rise_done: 1'b0,
    fall_done: 1'b0,
    armed:     1'b0,
    pos:       '0
  };

endpackage

`default_nettype wire

/* rtl/hppc_cfg_regs.sv */
// Configuration registers of the hall pulse position counter.
// Depends on hppc_pkg for the register indexes and the cfg_t record.
`default_nettype none

module hppc_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [hppc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [hppc_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output hppc_pkg::cfg_t                          cfg
);
  import hppc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_jump   <= 12'd200;
      cfg.diag_high  <= 12'd4000;
      cfg.diag_low   <= 12'd50;
      cfg.min_ampl   <= 12'd100;
      cfg.decel_time <= 16'd500;
      cfg.tick_step  <= 16'd10;
      cfg.pos_min    <= -16'sd32768;
      cfg.pos_max    <= 16'sd32767;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_JUMP:   cfg.max_jump   <= cfg_data[SAMPLE_BITS-1:0];
        CFG_DIAG_HIGH:  cfg.diag_high  <= cfg_data[SAMPLE_BITS-1:0];
        CFG_DIAG_LOW:   cfg.diag_low   <= cfg_data[SAMPLE_BITS-1:0];
        CFG_MIN_AMPL:   cfg.min_ampl   <= cfg_data[SAMPLE_BITS-1:0];
        CFG_DECEL_TIME: cfg.decel_time <= cfg_data[TIME_BITS-1:0];
        CFG_TICK_STEP:  cfg.tick_step  <= cfg_data[TIME_BITS-1:0];
        CFG_POS_MIN:    cfg.pos_min    <= $signed(cfg_data[POS_BITS-1:0]);
        CFG_POS_MAX:    cfg.pos_max    <= $signed(cfg_data[POS_BITS-1:0]);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/hppc_update.sv */
// Next-state and result logic for one channel and one request.
// Depends on hppc_pkg for the state, request, result and configuration types.
`default_nettype none

module hppc_update (
  input  wire hppc_pkg::chan_state_t cur,
  input  wire hppc_pkg::item_t       item,
  input  wire hppc_pkg::cfg_t        cfg,
  output hppc_pkg::chan_state_t      nxt,
  output hppc_pkg::result_t          res
);
  import hppc_pkg::*;

  function automatic logic [TRACK_BITS-1:0] abs_diff(input logic [TRACK_BITS-1:0] a,
                                                     input logic [TRACK_BITS-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic chan_state_t clear_track(input chan_state_t c);
    chan_state_t r;
    r = c;
    r.track_max = TRACK_MAX_CLR;
    r.prev_max  = TRACK_MAX_CLR;
    r.track_min = TRACK_MIN_CLR;
    r.prev_min  = TRACK_MIN_CLR;
    r.armed     = 1'b0;
    return r;
  endfunction

  function automatic logic signed [POS_BITS-1:0] step_pos(
      input logic signed [POS_BITS-1:0] pos,
      input logic [1:0]                 dir,
      input logic [1:0]                 stall,
      input logic signed [POS_BITS-1:0] pmin,
      input logic signed [POS_BITS-1:0] pmax);
    logic up;
    logic down;
    up   = ((dir == DIR_FW) && (stall != STALL_FW)) || ((dir == DIR_BW) && (stall == STALL_BW));
    down = ((dir == DIR_FW) && (stall == STALL_FW)) || ((dir == DIR_BW) && (stall != STALL_BW));
    if (up && (pos < pmax)) begin
      return pos + 16'sd1;
    end else if (down && (pos > pmin)) begin
      return pos - 16'sd1;
    end
    return pos;
  endfunction

  logic [TRACK_BITS-1:0] smp;
  logic [TRACK_BITS-1:0] jump;
  logic [TRACK_BITS-1:0] ampl;

  assign smp  = TRACK_BITS'(item.sample);
  assign jump = TRACK_BITS'(cfg.max_jump);
  assign ampl = TRACK_BITS'(cfg.min_ampl);

  always_comb begin
    chan_state_t           st;
    logic                  en;
    logic                  e_max;
    logic                  e_min;
    logic                  e_slc;
    logic [TRACK_BITS-1:0] range;
    logic [TRACK_BITS-1:0] thr;

    st    = cur;
    en    = 1'b0;
    e_max = 1'b0;
    e_min = 1'b0;
    e_slc = 1'b0;
    range = '0;
    thr   = '0;

    if (item.opcode == OP_LOAD) begin
      st.pos = item.new_position;
    end else begin
      if (item.direction != DIR_IDLE) begin
        en          = 1'b1;
        st.last_dir = item.direction;
        st.decel    = cfg.decel_time;
      end else if (st.decel != '0) begin
        st.decel = (st.decel > cfg.tick_step) ? (st.decel - cfg.tick_step) : '0;
        if (st.decel == '0) begin
          st.last_dir = DIR_IDLE;
          st = clear_track(st);
        end else begin
          en = 1'b1;
        end
      end

      if (en) begin
        if (smp > st.track_max) begin
          if ((abs_diff(st.prev_max, smp) < jump) && (item.sample < cfg.diag_high)) begin
            if (st.armed && ((smp - st.track_max) > ampl)) begin
              st    = clear_track(st);
              e_max = 1'b1;
            end else begin
              st.track_max = smp;
            end
          end
          st.prev_max = smp;
        end
        if (smp < st.track_min) begin
          if ((abs_diff(st.prev_min, smp) < jump) && (item.sample > cfg.diag_low)) begin
            if (st.armed && ((st.track_min - smp) > ampl)) begin
              st    = clear_track(st);
              e_min = 1'b1;
            end else begin
              st.track_min = smp;
            end
          end
          st.prev_min = smp;
        end
        if (st.track_max > st.track_min) begin
          range = st.track_max - st.track_min;
          thr   = st.track_min + (range >> 1);
          if (range > ampl) begin
            st.armed = 1'b1;
            if (smp > thr) begin
              if (st.sliced) begin
                if (!st.rise_done) begin
                  st.rise_done = 1'b1;
                  st.fall_done = 1'b0;
                  e_slc        = 1'b1;
                end
              end else begin
                st.sliced = 1'b1;
              end
            end else begin
              if (!st.sliced) begin
                if (!st.fall_done) begin
                  st.fall_done = 1'b1;
                  st.rise_done = 1'b0;
                  e_slc        = 1'b1;
                end
              end else begin
                st.sliced = 1'b0;
              end
            end
          end
        end
      end

      if (e_max) begin
        st.pos = step_pos(st.pos, st.last_dir, item.stall_req, cfg.pos_min, cfg.pos_max);
      end
      if (e_min) begin
        st.pos = step_pos(st.pos, st.last_dir, item.stall_req, cfg.pos_min, cfg.pos_max);
      end
      if (e_slc) begin
        st.pos = step_pos(st.pos, st.last_dir, item.stall_req, cfg.pos_min, cfg.pos_max);
      end
    end

    nxt                 = st;
    res.position        = st.pos;
    res.level           = st.sliced;
    res.edges_counted   = 2'({1'b0, e_max} + {1'b0, e_min} + {1'b0, e_slc});
    res.counting_active = en;
  end

endmodule

`default_nettype wire

/* rtl/hall_pulse_position_counter.sv */
// Hall pulse position counter: channel state, request register, result register.
// Depends on hppc_pkg, hppc_cfg_regs and hppc_update.
//
// Requests arrive on the s_ group; s_tuser is the opcode (tick or load) and
// s_tdata carries channel, sample, direction, stall status and load value.
// Each request yields exactly one result on the m_ group: channel position,
// sliced level, edges counted by this request and the counting flag.
// A request is taken into an input register; from there the addressed
// channel's state is read, updated by the combinational update logic and
// written back while the result is loaded into the output register.
// Throughput is one request per cycle while no result waits on m_tready,
// also on the same channel back to back, since the state read and write
// both happen in the update stage.
// When m_tready is low the result holds, one more request waits in the input
// register, and s_tready drops until the result is taken.
// Reset clears all channel state, the configuration registers to their
// defaults and both valid flags. Configuration writes take effect at once.
`default_nettype none

module hall_pulse_position_counter (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output      logic                               s_tready,
  // channel[1:0], sample[13:2], direction[15:14], stall_req[17:16],
  // new_position[33:18], zero fill above
  input  wire logic [hppc_pkg::IN_DATA_BITS-1:0]  s_tdata,
  // opcode
  input  wire logic                               s_tuser,
  output      logic                               m_tvalid,
  input  wire logic                               m_tready,
  // position[15:0], level[16], edges_counted[18:17], counting_active[19],
  // zero fill above
  output      logic [hppc_pkg::OUT_DATA_BITS-1:0] m_tdata,
  input  wire logic                               cfg_we,
  input  wire logic [hppc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [hppc_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import hppc_pkg::*;

  cfg_t        cfg;
  item_t       item_in;
  item_t       item_q;
  logic        item_valid;
  logic        advance;
  chan_state_t chan_q [NUM_CHANNELS];
  chan_state_t cur;
  chan_state_t nxt;
  result_t     res;
  result_t     res_q;

  hppc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign item_in.opcode       = opcode_t'(s_tuser);
  assign item_in.channel      = s_tdata[1:0];
  assign item_in.sample       = s_tdata[13:2];
  assign item_in.direction    = s_tdata[15:14];
  assign item_in.stall_req    = s_tdata[17:16];
  assign item_in.new_position = $signed(s_tdata[33:18]);

  assign advance  = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_q <= item_in;
    end
  end

  assign cur = chan_q[item_q.channel];

  hppc_update u_update (
    .cur  (cur),
    .item (item_q),
    .cfg  (cfg),
    .nxt  (nxt),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan_q[i] <= CHAN_RESET;
      end
    end else if (advance) begin
      chan_q[item_q.channel] <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_tdata = {4'd0, res_q.counting_active, res_q.edges_counted, res_q.level,
                    res_q.position};

endmodule

`default_nettype wire
